// ===== rtl/tpspwm_pkg.sv =====
// Shared types, constants and the sine table for the three-phase sine PWM block.
package tpspwm_pkg;

  localparam int unsigned FREQ_W     = 6;
  localparam int unsigned CMP_W      = 13;
  localparam int unsigned RELOAD_W   = 22;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned SINE_W     = 13;
  localparam int unsigned MAG_W      = 18;
  localparam int unsigned DVND_W     = 27;
  localparam int unsigned DVSR_W     = 11;
  localparam int unsigned RECIP_W    = 19;
  // floor(x / 100) == (x * AMP_RECIP) >> AMP_SHIFT for every x below 2^18
  localparam int unsigned AMP_SHIFT  = 25;

  localparam logic [IDX_W-1:0]    ROM_LAST    = 5'd29;
  localparam logic [IDX_W-1:0]    OFS_B       = 5'd10;
  localparam logic [IDX_W-1:0]    OFS_C       = 5'd20;
  localparam logic [IDX_W-1:0]    ROM_LEN     = 5'd30;
  localparam logic [FREQ_W-1:0]   FREQ_MIN    = 6'd1;
  localparam logic [FREQ_W-1:0]   FREQ_MAX    = 6'd60;
  localparam logic [CMP_W-1:0]    CENTER_RST  = 13'd4000;
  localparam logic [CMP_W-1:0]    COMPARE_MAX = 13'd8000;
  localparam logic [RECIP_W-1:0]  AMP_RECIP   = 19'd335545;
  localparam logic [MAG_W-1:0]    AMP_ROUND   = 18'd99;
  localparam logic [DVND_W-1:0]   RELOAD_NUM  = 27'd80000000;

  typedef struct packed {
    logic              start;
    logic [DVND_W-1:0] dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVND_W-1:0] quotient;
  } div_rsp_t;

  // One period of the sine in 30 steps; indexes past the end read mod 30.
  function automatic logic signed [SINE_W-1:0] sine_val(input logic [IDX_W-1:0] idx);
    logic signed [SINE_W-1:0] v;
    case (idx)
      5'd0:  v = 13'sd50;
      5'd1:  v = 13'sd810;
      5'd2:  v = 13'sd1586;
      5'd3:  v = 13'sd2292;
      5'd4:  v = 13'sd2898;
      5'd5:  v = 13'sd3377;
      5'd6:  v = 13'sd3709;
      5'd7:  v = 13'sd3878;
      5'd8:  v = 13'sd3878;
      5'd9:  v = 13'sd3709;
      5'd10: v = 13'sd3377;
      5'd11: v = 13'sd2898;
      5'd12: v = 13'sd2292;
      5'd13: v = 13'sd1586;
      5'd14: v = 13'sd810;
      5'd15: v = 13'sd50;
      5'd16: v = -13'sd810;
      5'd17: v = -13'sd1586;
      5'd18: v = -13'sd2292;
      5'd19: v = -13'sd2898;
      5'd20: v = -13'sd3377;
      5'd21: v = -13'sd3709;
      5'd22: v = -13'sd3878;
      5'd23: v = -13'sd3878;
      5'd24: v = -13'sd3709;
      5'd25: v = -13'sd3377;
      5'd26: v = -13'sd2898;
      5'd27: v = -13'sd2292;
      5'd28: v = -13'sd1586;
      5'd29: v = -13'sd810;
      5'd30: v = 13'sd50;
      default: v = 13'sd810;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tpspwm_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the update-timer reload.
module tpspwm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tpspwm_pkg::div_req_t req,
  output tpspwm_pkg::div_rsp_t rsp
);

  localparam int unsigned DVND_W = tpspwm_pkg::DVND_W;
  localparam int unsigned DVSR_W = tpspwm_pkg::DVSR_W;
  localparam logic [4:0]  LAST_STEP = 5'(DVND_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DVND_W-1:0] quo_r, quo_nxt;
  logic [DVSR_W-1:0] dvsr_r, dvsr_nxt;

  logic [DVSR_W:0]   shifted;
  logic [DVSR_W+1:0] diff;

  assign shifted = {rem_r, quo_r[DVND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      // keep the trial difference when it does not go negative
      if (!diff[DVSR_W+1]) begin
        rem_nxt = diff[DVSR_W-1:0];
      end else begin
        rem_nxt = shifted[DVSR_W-1:0];
      end
      quo_nxt = {quo_r[DVND_W-2:0], ~diff[DVSR_W+1]};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/three_phase_sine_pwm_vf.sv =====
// Top level of the three-phase sine PWM update with constant volts per hertz.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-------------------------------------------
//  in_     | in  | in_tvalid / in_tready   | tdata: sine_freq, reverse
//  out_    | out | out_tvalid / out_tready | tdata: a, b, c compares, reload; tlast: wrap
//  cfg_    | in  | APB, pready always high | center_count at byte address 0
//
// Each request is worked on from acceptance until in_tready returns, and
// out_tvalid rises in that same cycle. Per phase the steps are table read and
// product, multiply by the reciprocal of 100, and apply and clip; then the
// reload divide 80000000 / (31 * freq) is started, runs one divider step per bit
// of the 27-bit dividend, and the quotient is taken and loaded into the output register.
// in_tready is high only while the sequencer is idle; one request is in work at a time.
// A finished result sits in the output register; the sequencer holds in its
// last state until that register is free. Reset is synchronous, active low,
// and sets center_count to 4000 and the phase index to zero.
module three_phase_sine_pwm_vf (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [5:0] sine_freq, [6] reverse, [7] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [12:0] a, [25:13] b, [38:26] c, [60:39] reload, rest zero
  output logic        out_tlast,   // cycle_wrap
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned FREQ_W   = tpspwm_pkg::FREQ_W;
  localparam int unsigned CMP_W    = tpspwm_pkg::CMP_W;
  localparam int unsigned RELOAD_W = tpspwm_pkg::RELOAD_W;
  localparam int unsigned IDX_W    = tpspwm_pkg::IDX_W;
  localparam int unsigned MAG_W    = tpspwm_pkg::MAG_W;
  localparam int unsigned DVSR_W   = tpspwm_pkg::DVSR_W;
  localparam int unsigned PROD_W   = MAG_W + tpspwm_pkg::RECIP_W;
  localparam int unsigned SUM_W    = 15;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_RLD   = 3'd4;
  localparam logic [2:0] S_RWAIT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [1:0] PH_LAST = 2'd2;

  logic [2:0]          state_r, state_nxt;
  logic [CMP_W-1:0]    center_r;
  logic [IDX_W-1:0]    phase_idx_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [IDX_W-1:0]    rd_idx_r [3];
  logic                wrap_r;
  logic [1:0]          ph_r;
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CMP_W-1:0]    cmp_r [3];
  logic [RELOAD_W-1:0] reload_r;
  logic                out_valid_r;
  logic [63:0]         out_data_r;
  logic                out_last_r;

  tpspwm_pkg::div_req_t div_req;
  tpspwm_pkg::div_rsp_t div_rsp;

  logic                in_acc;
  logic                cfg_wr;
  logic [FREQ_W-1:0]   freq_in;
  logic                rev_in;
  logic [FREQ_W-1:0]   freq_clamp;
  logic [IDX_W:0]      idx_b_sum, idx_c_sum;
  logic [IDX_W-1:0]    idx_b, idx_c;
  logic signed [tpspwm_pkg::SINE_W-1:0] sine_s;
  logic [tpspwm_pkg::SINE_W-1:0]        sine_abs;
  logic [MAG_W-1:0]    mag_calc;
  logic [11:0]         q_amp;
  logic signed [SUM_W-1:0] sum;
  logic [CMP_W-1:0]    cmp_sat;
  logic                out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign freq_in   = in_tdata[FREQ_W-1:0];
  assign rev_in    = in_tdata[FREQ_W];
  assign out_free  = !out_valid_r || out_tready;

  // clamp the commanded frequency into 1..60
  always_comb begin
    if (freq_in < tpspwm_pkg::FREQ_MIN) begin
      freq_clamp = tpspwm_pkg::FREQ_MIN;
    end else if (freq_in > tpspwm_pkg::FREQ_MAX) begin
      freq_clamp = tpspwm_pkg::FREQ_MAX;
    end else begin
      freq_clamp = freq_in;
    end
  end

  // phase B and C sit 10 and 20 steps ahead, mod 30
  assign idx_b_sum = {1'b0, phase_idx_r} + {1'b0, tpspwm_pkg::OFS_B};
  assign idx_c_sum = {1'b0, phase_idx_r} + {1'b0, tpspwm_pkg::OFS_C};
  assign idx_b = (idx_b_sum >= {1'b0, tpspwm_pkg::ROM_LEN}) ?
                 IDX_W'(idx_b_sum - {1'b0, tpspwm_pkg::ROM_LEN}) : idx_b_sum[IDX_W-1:0];
  assign idx_c = (idx_c_sum >= {1'b0, tpspwm_pkg::ROM_LEN}) ?
                 IDX_W'(idx_c_sum - {1'b0, tpspwm_pkg::ROM_LEN}) : idx_c_sum[IDX_W-1:0];

  // table read and magnitude product for the phase in work
  assign sine_s   = tpspwm_pkg::sine_val(rd_idx_r[ph_r]);
  assign sine_abs = sine_s[tpspwm_pkg::SINE_W-1] ? 13'(-sine_s) : 13'(sine_s);
  assign mag_calc = MAG_W'(sine_abs[11:0]) * MAG_W'(freq_r);

  // apply the signed, floored amplitude to the center and clip to 0..8000
  assign q_amp = prod_r[tpspwm_pkg::AMP_SHIFT +: 12];
  assign sum   = neg_r ? $signed({2'b00, center_r}) - $signed({3'b000, q_amp})
                       : $signed({2'b00, center_r}) + $signed({3'b000, q_amp});
  always_comb begin
    if (sum < 0) begin
      cmp_sat = '0;
    end else if (sum > $signed({2'b00, tpspwm_pkg::COMPARE_MAX})) begin
      cmp_sat = tpspwm_pkg::COMPARE_MAX;
    end else begin
      cmp_sat = sum[CMP_W-1:0];
    end
  end

  // reload divide: 80000000 / (31 * freq)
  always_comb begin
    div_req.start    = (state_r == S_RLD);
    div_req.dividend = tpspwm_pkg::RELOAD_NUM;
    div_req.divisor  = {freq_r, 5'b00000} - DVSR_W'(freq_r);
  end

  tpspwm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_APPLY;
      S_APPLY: state_nxt = (ph_r == PH_LAST) ? S_RLD : S_MUL;
      S_RLD:   state_nxt = S_RWAIT;
      S_RWAIT: if (div_rsp.done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      center_r    <= tpspwm_pkg::CENTER_RST;
      phase_idx_r <= '0;
      out_valid_r <= 1'b0;
      ph_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && !cfg_paddr[2]) begin
        center_r <= cfg_pwdata[CMP_W-1:0];
      end
      // advance the phase index at acceptance, wrapping 29 -> 0
      if (in_acc) begin
        phase_idx_r <= (phase_idx_r >= tpspwm_pkg::ROM_LAST) ? '0 : phase_idx_r + 5'd1;
        ph_r        <= '0;
      end else if (state_r == S_APPLY && ph_r != PH_LAST) begin
        ph_r <= ph_r + 2'd1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      freq_r      <= freq_clamp;
      wrap_r      <= (phase_idx_r >= tpspwm_pkg::ROM_LAST);
      rd_idx_r[0] <= phase_idx_r;
      rd_idx_r[1] <= rev_in ? idx_c : idx_b;
      rd_idx_r[2] <= rev_in ? idx_b : idx_c;
    end
    if (state_r == S_MUL) begin
      // negative samples round toward minus infinity: scale |p| + 99
      mag_r <= sine_s[tpspwm_pkg::SINE_W-1] ? mag_calc + tpspwm_pkg::AMP_ROUND : mag_calc;
      neg_r <= sine_s[tpspwm_pkg::SINE_W-1];
    end
    if (state_r == S_SCALE) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(tpspwm_pkg::AMP_RECIP);
    end
    if (state_r == S_APPLY) begin
      cmp_r[ph_r] <= cmp_sat;
    end
    if (state_r == S_RWAIT && div_rsp.done) begin
      reload_r <= div_rsp.quotient[RELOAD_W-1:0];
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {3'b000, reload_r, cmp_r[2], cmp_r[1], cmp_r[0]};
      out_last_r <= wrap_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {19'd0, center_r};

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for three_phase_sine_pwm_vf: directed table, random phases, scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FW = tpspwm_pkg::FREQ_W;
  localparam int unsigned CW = tpspwm_pkg::CMP_W;
  localparam int unsigned RW = tpspwm_pkg::RELOAD_W;

  // Own constants of the update law.
  localparam int SINE_STEPS      = 30;
  localparam int OFS_2ND         = 10;
  localparam int OFS_3RD         = 20;
  localparam int F_LO            = 1;
  localparam int F_HI            = 60;
  localparam int CMP_TOP         = 8000;
  localparam int AMP_SCALE       = 100;
  localparam int RELOAD_DIVIDEND = 80000000;
  localparam int STEPS_PER_TICK  = 31;
  localparam int CENTER_DEFAULT  = 4000;
  localparam int CENTER_MASK     = 32'h1FFF;

  localparam logic [2:0] CENTER_ADDR = 3'd0;

  // Stimulus shape.
  localparam int DIR_ROWS    = 24;
  localparam int DIR_KNOWN   = 3;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 161;
  localparam int TAIL_CYCLES = 150;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_AT     = 20000;
  localparam int HOLD_LEN    = 900;

  typedef struct packed {
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] c;
    logic [RW-1:0] reload;
    logic          wrap;
  } pwm_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [5:0] sine_freq, [6] reverse, [7] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [12:0] a, [25:13] b, [38:26] c, [60:39] reload
  logic        out_tlast;         // cycle_wrap
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  three_phase_sine_pwm_vf u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int cyc_count = 0;
  int err_count = 0;

  always @(posedge clk) cyc_count <= cyc_count + 1;

  // One sine period in 30 signed steps.
  int sine_tab [SINE_STEPS] = '{
    50, 810, 1586, 2292, 2898, 3377, 3709, 3878, 3878, 3709,
    3377, 2898, 2292, 1586, 810, 50, -810, -1586, -2292, -2898,
    -3377, -3709, -3878, -3878, -3709, -3377, -2898, -2292, -1586, -810
  };

  // Mirror of the block state and register.
  int            model_phase = 0;
  logic [CW-1:0] model_center = CW'(CENTER_DEFAULT);

  // Updates accepted but not yet seen on the output, oldest first.
  pwm_result_t pending_updates [$];

  // center + floor(sine * f / 100), clamped to 0..8000.
  function automatic logic [CW-1:0] scaled_compare(input int idx, input int f);
    int p;
    int q;
    int v;
    p = sine_tab[idx] * f;
    if (p >= 0) q = p / AMP_SCALE;
    else q = -((-p + AMP_SCALE - 1) / AMP_SCALE);
    v = int'(model_center) + q;
    if (v < 0) v = 0;
    if (v > CMP_TOP) v = CMP_TOP;
    return CW'(v);
  endfunction

  // Work out one update and advance the mirrored phase index.
  function automatic pwm_result_t next_pwm_update(input logic [FW-1:0] f_raw, input logic rev);
    pwm_result_t r;
    int f;
    int ia;
    int ib;
    int ic;
    int t;
    f = int'(f_raw);
    // Saturate the commanded frequency into 1..60.
    if (f < F_LO) f = F_LO;
    if (f > F_HI) f = F_HI;
    ia = model_phase % SINE_STEPS;
    ib = (ia + OFS_2ND) % SINE_STEPS;
    ic = (ia + OFS_3RD) % SINE_STEPS;
    // Reverse rotation: swap the second and third phases.
    if (rev) begin
      t  = ib;
      ib = ic;
      ic = t;
    end
    r.a      = scaled_compare(ia, f);
    r.b      = scaled_compare(ib, f);
    r.c      = scaled_compare(ic, f);
    r.reload = RW'(RELOAD_DIVIDEND / (STEPS_PER_TICK * f));
    ia = ia + 1;
    r.wrap = (ia >= SINE_STEPS);
    if (r.wrap) ia = 0;
    model_phase = ia;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Offer one request; called in the time step of a rising edge, returns at the
  // edge where it is taken. in_tvalid is only ever raised here; the task never lowers it.
  task automatic send_request(input logic [FW-1:0] f, input logic rev,
                              input bit known, input pwm_result_t known_r);
    pwm_result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, rev, f};
    do @(posedge clk); while (!in_tready);
    r = next_pwm_update(f, rev);
    // Where the answer is typed in by hand, that value is the expectation.
    if (known) r = known_r;
    pending_updates.push_back(r);
  endtask

  // One APB transfer: setup cycle, access cycle, wait for pready, then back to idle.
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read center_count back and compare with the mirror.
  task automatic check_center(input int exp_v);
    logic [31:0] rd;
    apb_xfer(1'b0, CENTER_ADDR, '0, rd);
    check_field("center_count readback", exp_v, int'(rd));
  endtask

  // Output monitor: every taken result is matched against the oldest expectation.
  always @(posedge clk) begin
    pwm_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_updates.size() == 0) begin
        err_count++;
        $display("%0t ns: result with nothing expected, expected none, actual %h wrap %0b",
                 $time, out_tdata, out_tlast);
      end else begin
        e = pending_updates.pop_front();
        check_field("phase_a_compare", int'(e.a),      int'(out_tdata[12:0]));
        check_field("phase_b_compare", int'(e.b),      int'(out_tdata[25:13]));
        check_field("phase_c_compare", int'(e.c),      int'(out_tdata[38:26]));
        check_field("tick_reload",     int'(e.reload), int'(out_tdata[60:39]));
        check_field("cycle_wrap",      int'(e.wrap),   int'(out_tlast));
      end
    end
  end

  // Receiver: pick a new stall mode whenever the low byte of cyc_count is zero; once, hold off
  // for a long stretch so the block fills up and drops in_tready while requests keep coming.
  initial begin : receiver
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cyc_count == HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      if (cyc_count[7:0] == 8'd0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_tready <= 1'b1;                           // no stalls at all
        1:       out_tready <= 1'($urandom_range(0, 1));       // coin flip
        2:       out_tready <= ($urandom_range(0, 7) == 0);    // mostly stalled
        default: out_tready <= ((cyc_count % 7) < 3);          // fixed duty pattern
      endcase
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cyc_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // Directed table: {reverse, sine_freq} per row. The first rows carry a hand
  // computed answer; the rest go through the predictor.
  logic [FW:0] dir_tab [DIR_ROWS] = '{
    {1'b0, 6'd0},  {1'b0, 6'd60}, {1'b1, 6'd63}, {1'b1, 6'd1},
    {1'b0, 6'd61}, {1'b1, 6'd32}, {1'b0, 6'd31}, {1'b0, 6'd42},
    {1'b1, 6'd21}, {1'b0, 6'd59}, {1'b1, 6'd2},  {1'b0, 6'd16},
    {1'b1, 6'd8},  {1'b0, 6'd4},  {1'b1, 6'd62}, {1'b0, 6'd30},
    {1'b1, 6'd45}, {1'b0, 6'd1},  {1'b1, 6'd60}, {1'b0, 6'd0},
    {1'b1, 6'd50}, {1'b0, 6'd10}, {1'b1, 6'd33}, {1'b0, 6'd57}
  };

  pwm_result_t dir_known [DIR_KNOWN];

  initial begin : stimulus
    int          burst_left;
    int          gap;
    int          sel;
    int          center_v;
    logic [31:0] wdata;
    logic [31:0] rd;
    logic [FW-1:0] f;
    logic        rev;

    // Index 0, lowest frequency after saturation: tiny amplitude, longest reload.
    dir_known[0] = {13'd4000, 13'd4033, 13'd3966, 22'd2580645, 1'b0};
    // Index 1 at full 60 Hz: shortest reload.
    dir_known[1] = {13'd4486, 13'd5738, 13'd1774, 22'd43010, 1'b0};
    // Index 2, 63 saturates to 60, reverse swaps b and c.
    dir_known[2] = {13'd4951, 13'd1673, 13'd5375, 22'd43010, 1'b0};

    // Hold reset low, then release.
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register comes out of reset at its default.
    check_center(CENTER_DEFAULT);

    // Directed rows back to back.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_tab[i][FW-1:0], dir_tab[i][FW], i < DIR_KNOWN,
                   (i < DIR_KNOWN) ? dir_known[i] : '0);
    end
    in_tvalid <= 1'b0;

    burst_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Drain before touching the register; the block is idle once the last
      // expected result is out since every request yields one result.
      while (pending_updates.size() != 0) @(posedge clk);
      if (ph > 0) begin
        case (ph)
          1:       center_v = 0;                                 // clamps low
          2:       center_v = CENTER_MASK;                       // clamps high
          3:       center_v = 2327;                              // low edge of safe range
          4:       center_v = 5673;                              // high edge of safe range
          5:       center_v = $urandom_range(0, CENTER_MASK);
          default: center_v = $urandom_range(2327, 5673);
        endcase
        // Junk in the upper bits; only the low 13 are kept.
        wdata = $urandom;
        wdata[CW-1:0] = CW'(center_v);
        apb_xfer(1'b1, CENTER_ADDR, wdata, rd);
        model_center = CW'(center_v);
        check_center(center_v);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Bursts with random gaps between them; a zero gap merges bursts.
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
          sel = $urandom_range(0, 9);
          if (sel < 7) gap = $urandom_range(1, 8);
          else if (sel < 9) gap = $urandom_range(20, 140);
          else gap = 0;
          if (gap > 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        // Mostly legal frequencies, some zero and some above 60 to saturate.
        sel = $urandom_range(0, 19);
        if (sel == 0) f = '0;
        else if (sel == 1) f = FW'($urandom_range(61, 63));
        else f = FW'($urandom_range(F_LO, F_HI));
        rev = 1'($urandom_range(0, 1));
        send_request(f, rev, 1'b0, '0);
      end
      in_tvalid <= 1'b0;
    end

    // Wait for the last results, then a little tail to catch strays.
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
